// ----- sv/sprgb_pkg.sv -----
// ----------------------------------------------------------------------------
// sprgb_pkg
// Register map, field widths and channel expansion helpers for the screen
// pixel to RGB converter.
// ----------------------------------------------------------------------------
package sprgb_pkg;

    // Register indexes (byte address is 4 * index)
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_FOUR      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FLIP_ROWS     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REPLACE_ALPHA = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_VALUE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET   = 3'd7;

    localparam int PADDR_W  = 5;
    localparam int SIZE_W   = 11;
    localparam int OFFS_W   = 16;
    localparam int ADDR_W   = 23;
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 32;
    localparam int OUT_DATA_W = 56;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CHAN_W-1:0] chan_t;

    // Result payload, last declared field in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic  pad;
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
        addr_t dest_addr;
    } out_data_t;

    // floor(c*255/31) = 8c + floor(7c/31)
    function automatic chan_t expand5(input logic [4:0] c);
        logic [7:0] seven_c;
        logic [2:0] frac;
        seven_c = {c, 3'b000} - {3'b000, c};
        frac    = 3'd0;
        for (int k = 1; k <= 7; k++)
        begin
            if (seven_c >= 8'(31 * k))
            begin
                frac = frac + 3'd1;
            end
        end
        return {c, 3'b000} + {5'b00000, frac};
    endfunction

    // floor(c*255/63) = 4c + floor(3c/63)
    function automatic chan_t expand6(input logic [5:0] c);
        logic [7:0] three_c;
        logic [1:0] frac;
        three_c = {1'b0, c, 1'b0} + {2'b00, c};
        frac    = 2'd0;
        for (int k = 1; k <= 3; k++)
        begin
            if (three_c >= 8'(63 * k))
            begin
                frac = frac + 2'd1;
            end
        end
        return {c, 2'b00} + {6'b000000, frac};
    endfunction

endpackage

// ----- sv/screen_pixel_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// screen_pixel_to_rgb_converter
// Expands RGB565 or passes ARGB source pixels to 8-bit channels and computes
// the destination byte address of each 3- or 4-byte output pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  s_tdata[31:0] = pixel_word
//  m_*       out  m_tvalid/m_tready  m_tdata = dest_addr, red, green, blue,
//                                    alpha (low bits up); m_tlast = frame_end
//  APB       in   psel/penable       8 registers at byte address 4*index
//
//  An accepted pixel passes the first, then the second stage to reach m_*; a
//  pixel is taken every cycle unless m_tready stalls. The first stage clamps
//  the row and column counters and forms the linear pixel index (the one row
//  times width multiply); the second scales it by the pixel size, adds the
//  base offset and expands the channels. A stall on m_tready holds both
//  stages; s_tready stays high while the first stage is empty or can move on.
//  Reset clears the counters and valids and loads the register reset values.
//
module screen_pixel_to_rgb_converter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel_word[31:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sprgb_pkg::PIXEL_W-1:0]       s_tdata,
    // dest_addr[22:0], red[30:23], green[38:31], blue[46:39], alpha[54:47]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sprgb_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sprgb_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sprgb_pkg::*;

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]    frame_width_reg;
    logic [SIZE_W-1:0]    frame_height_reg;
    logic                 source_wide_reg;
    logic                 out_four_reg;
    logic                 flip_rows_reg;
    logic                 replace_alpha_reg;
    chan_t                alpha_value_reg;
    logic [OFFS_W-1:0]    base_offset_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= SIZE_W'(1);
            frame_height_reg  <= SIZE_W'(1);
            source_wide_reg   <= 1'b0;
            out_four_reg      <= 1'b1;
            flip_rows_reg     <= 1'b0;
            replace_alpha_reg <= 1'b0;
            alpha_value_reg   <= 8'hFF;
            base_offset_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[SIZE_W-1:0];
                REG_SOURCE_WIDE:   source_wide_reg   <= pwdata[0];
                REG_OUT_FOUR:      out_four_reg      <= pwdata[0];
                REG_FLIP_ROWS:     flip_rows_reg     <= pwdata[0];
                REG_REPLACE_ALPHA: replace_alpha_reg <= pwdata[0];
                REG_ALPHA_VALUE:   alpha_value_reg   <= pwdata[CHAN_W-1:0];
                REG_BASE_OFFSET:   base_offset_reg   <= pwdata[OFFS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:   prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT:  prdata = 32'(frame_height_reg);
            REG_SOURCE_WIDE:   prdata = 32'(source_wide_reg);
            REG_OUT_FOUR:      prdata = 32'(out_four_reg);
            REG_FLIP_ROWS:     prdata = 32'(flip_rows_reg);
            REG_REPLACE_ALPHA: prdata = 32'(replace_alpha_reg);
            REG_ALPHA_VALUE:   prdata = 32'(alpha_value_reg);
            REG_BASE_OFFSET:   prdata = 32'(base_offset_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame size: zero acts as one, clamp to the maximum
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] eff_w;
    logic [SIZE_W-1:0] eff_h;

    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = SIZE_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            eff_w = SIZE_W'(MAX_WIDTH);
        else
            eff_w = frame_width_reg;

        if (frame_height_reg == '0)
            eff_h = SIZE_W'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            eff_h = SIZE_W'(MAX_HEIGHT);
        else
            eff_h = frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake: two stages, each advances when the one after can take it
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s1_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_load;
    assign s1_load  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Stage 1: clamp counters, form linear pixel index, advance counters
    // ------------------------------------------------------------------
    logic [CW-1:0]       col_cnt_reg, col_cnt_next;
    logic [RW-1:0]       row_cnt_reg, row_cnt_next;
    logic [CW-1:0]       col;
    logic [RW-1:0]       row;
    logic [RW-1:0]       out_row;
    logic                last_col;
    logic                last_row;
    addr_t               lin_idx;

    logic [PIXEL_W-1:0]  s1_pixel_reg;
    addr_t               s1_lin_reg;
    logic                s1_last_reg;

    always_comb
    begin
        // a counter past a shrunken frame is taken as its last value
        col = (32'(col_cnt_reg) >= 32'(eff_w)) ? CW'(eff_w - SIZE_W'(1)) : col_cnt_reg;
        row = (32'(row_cnt_reg) >= 32'(eff_h)) ? RW'(eff_h - SIZE_W'(1)) : row_cnt_reg;

        last_col = (32'(col) == 32'(eff_w) - 32'd1);
        last_row = (32'(row) == 32'(eff_h) - 32'd1);

        out_row = flip_rows_reg ? RW'(eff_h - SIZE_W'(1) - SIZE_W'(row)) : row;
        lin_idx = ADDR_W'(ADDR_W'(out_row) * ADDR_W'(eff_w)) + ADDR_W'(col);

        if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : RW'(row + RW'(1));
        end
        else
        begin
            col_cnt_next = CW'(col + CW'(1));
            row_cnt_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (s_tready)
                s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pixel_reg <= s_tdata;
            s1_lin_reg   <= lin_idx;
            s1_last_reg  <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: byte address and channel expansion
    // ------------------------------------------------------------------
    out_data_t res;
    addr_t     byte_off;
    out_data_t out_data_reg;
    logic      out_last_reg;

    always_comb
    begin
        // pixel size 4 is a shift, 3 is index plus twice index
        byte_off = out_four_reg ? {s1_lin_reg[ADDR_W-3:0], 2'b00}
                                : s1_lin_reg + {s1_lin_reg[ADDR_W-2:0], 1'b0};
        res.pad       = 1'b0;
        res.dest_addr = ADDR_W'(base_offset_reg) + byte_off;

        if (source_wide_reg)
        begin
            res.red   = s1_pixel_reg[23:16];
            res.green = s1_pixel_reg[15:8];
            res.blue  = s1_pixel_reg[7:0];
            res.alpha = replace_alpha_reg ? alpha_value_reg : s1_pixel_reg[31:24];
        end
        else
        begin
            res.red   = expand5(s1_pixel_reg[15:11]);
            res.green = expand6(s1_pixel_reg[10:5]);
            res.blue  = expand5(s1_pixel_reg[4:0]);
            res.alpha = replace_alpha_reg ? alpha_value_reg : 8'hFF;
        end

        // drop alpha for three-byte output
        if (!out_four_reg)
            res.alpha = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_data_reg <= res;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
